// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// An implication or plain property that holds on every clock edge out of reset.
`define ASSERT_PROP(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// A condition that must never be seen on a clock edge out of reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif

`endif

// ===== rtl/mck_pkg.sv =====
// ---------------------------------------------------------------------------
// Morse keyer package
// Constants, phase codes, register indexes and the letter table.
// ---------------------------------------------------------------------------
`default_nettype none

package mck_pkg;

  // Counter and element limits.
  localparam int unsigned TICK_COUNT_BITS = 8;
  localparam int unsigned MAX_ELEMENTS    = 4;
  localparam int unsigned GAP_BITS        = 8;

  typedef logic [TICK_COUNT_BITS-1:0] tick_t;
  typedef logic [GAP_BITS-1:0]        gap_t;

  // Keyer phase codes.
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MARK = 3'd1;
  localparam logic [2:0] PH_EGAP = 3'd2;
  localparam logic [2:0] PH_CGAP = 3'd3;
  localparam logic [2:0] PH_WGAP = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_ELEMENT_GAP = 2'd0;
  localparam logic [1:0] REG_CHAR_GAP    = 2'd1;
  localparam logic [1:0] REG_WORD_GAP    = 2'd2;

  // Register reset values.
  localparam gap_t ELEMENT_GAP_RST = 8'd5;
  localparam gap_t CHAR_GAP_RST    = 8'd3;
  localparam gap_t WORD_GAP_RST    = 8'd7;

  // Character codes.
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CASE_MASK   = 8'hDF;
  localparam logic [7:0] CHAR_UPPR_A = 8'h41;
  localparam logic [7:0] CHAR_UPPR_Z = 8'h5A;

  // Mark lengths in ticks.
  localparam gap_t DOT_TICKS  = 8'd1;
  localparam gap_t DASH_TICKS = 8'd3;

  localparam logic [31:0] TICK_MAX = 32'((64'd1 << TICK_COUNT_BITS) - 64'd1);

  // Saturate an 8-bit count into the tick counter width.
  function automatic tick_t clamp_ticks(input gap_t v);
    logic [31:0] wide;
    wide = {{(32-GAP_BITS){1'b0}}, v};
    if (wide > TICK_MAX) begin
      clamp_ticks = tick_t'(TICK_MAX);
    end else begin
      clamp_ticks = tick_t'(wide);
    end
  endfunction

  // Per letter: element count in the high nibble, pattern in the low nibble
  // (bit i is element i, a one is a dash).
  function automatic logic [7:0] letter_code(input logic [4:0] idx);
    case (idx)
      5'd0:    letter_code = 8'h22;
      5'd1:    letter_code = 8'h41;
      5'd2:    letter_code = 8'h45;
      5'd3:    letter_code = 8'h31;
      5'd4:    letter_code = 8'h10;
      5'd5:    letter_code = 8'h44;
      5'd6:    letter_code = 8'h33;
      5'd7:    letter_code = 8'h40;
      5'd8:    letter_code = 8'h20;
      5'd9:    letter_code = 8'h4E;
      5'd10:   letter_code = 8'h35;
      5'd11:   letter_code = 8'h42;
      5'd12:   letter_code = 8'h23;
      5'd13:   letter_code = 8'h21;
      5'd14:   letter_code = 8'h37;
      5'd15:   letter_code = 8'h46;
      5'd16:   letter_code = 8'h4B;
      5'd17:   letter_code = 8'h32;
      5'd18:   letter_code = 8'h30;
      5'd19:   letter_code = 8'h11;
      5'd20:   letter_code = 8'h34;
      5'd21:   letter_code = 8'h48;
      5'd22:   letter_code = 8'h36;
      5'd23:   letter_code = 8'h49;
      5'd24:   letter_code = 8'h4D;
      5'd25:   letter_code = 8'h43;
      default: letter_code = 8'h00;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/morse_code_keyer_unit.sv =====
// ---------------------------------------------------------------------------
// Morse code keyer
// Keys one lamp from character and tick items with configurable gaps.
// ---------------------------------------------------------------------------
// Usage:
// Items enter on the s_axis channel: s_axis_tuser is the operation (0 sends
// the character in s_axis_tdata, 1 is one time tick). Every input transfer
// gives exactly one result transfer on m_axis with the lamp level, the busy
// flag and whether a character was taken. A character that arrives while a
// letter or gap is still being timed is refused and changes nothing.
// The result of an item is presented in the cycle after its transfer.
// Throughput is one item per cycle; the next state is worked out by the
// decrement and table lookup between the state registers and the result
// register. When the receiver stalls, the result register holds and
// s_axis_tready drops until the result is taken.
// The cfg channel writes the three gap registers (index 0: element gap,
// 1: character gap, 2: word gap) and is always ready; write it only while
// the keyer is idle. Reset puts the keyer idle with the lamp dark, the gaps
// at 5, 3 and 7 ticks and no result pending.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module morse_code_keyer_unit
  import mck_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Input item channel
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  wire logic       s_axis_tuser,   // [0] operation
  // Result channel
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [0] lamp_on, [1] busy_res, [2] accepted, rest 0
  // Configuration write channel
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  // Configuration registers.
  gap_t element_gap_q, char_gap_q, word_gap_q;

  // Keyer state.
  logic [2:0] phase_q, phase_d;
  tick_t      ticks_q, ticks_d;
  logic [3:0] pattern_q, pattern_d;
  logic [2:0] left_q, left_d;

  // Result register.
  logic       out_valid_q;
  logic [2:0] out_data_q, out_data_d;

  logic       in_xfer;
  logic       taken;
  logic       do_after;
  logic [7:0] folded;
  logic [7:0] code;
  logic [3:0] len;
  logic [4:0] letter_idx;

  // Take a new item whenever the result register is free or being emptied.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Case folding and letter lookup.
  assign folded     = s_axis_tdata & CASE_MASK;
  assign letter_idx = 5'(folded - CHAR_UPPR_A);
  assign code       = letter_code(letter_idx);

  // Element count limited to the longest supported letter.
  always_comb begin
    if (code[7:4] > 4'(MAX_ELEMENTS)) begin
      len = 4'(MAX_ELEMENTS);
    end else begin
      len = code[7:4];
    end
  end

  // Next state for one item.
  always_comb begin
    phase_d   = phase_q;
    ticks_d   = ticks_q;
    pattern_d = pattern_q;
    left_d    = left_q;
    taken     = 1'b0;
    do_after  = 1'b0;

    if (s_axis_tuser) begin
      // Tick: count down, and on expiry move to the following phase.
      if (phase_q != PH_IDLE) begin
        if (ticks_q > tick_t'(1)) begin
          ticks_d = ticks_q - tick_t'(1);
        end else begin
          ticks_d = '0;
          case (phase_q)
            PH_MARK: begin
              ticks_d = clamp_ticks(element_gap_q);
              if (ticks_d == '0) begin
                phase_d  = PH_IDLE;
                do_after = 1'b1;
              end else begin
                phase_d = PH_EGAP;
              end
            end
            PH_EGAP: begin
              do_after = 1'b1;
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
      end
    end else if (phase_q == PH_IDLE) begin
      // Character while idle: a space, a letter, or anything else ignored.
      taken = 1'b1;
      if (s_axis_tdata == CHAR_SPACE) begin
        ticks_d = clamp_ticks(word_gap_q);
        phase_d = (ticks_d != '0) ? PH_WGAP : PH_IDLE;
      end else if (folded >= CHAR_UPPR_A && folded <= CHAR_UPPR_Z) begin
        if (len != '0) begin
          left_d    = 3'(len - 4'd1);
          ticks_d   = clamp_ticks(code[0] ? DASH_TICKS : DOT_TICKS);
          pattern_d = {1'b0, code[3:1]};
          phase_d   = PH_MARK;
        end
      end
    end

    // After an element gap: next mark, or the character gap.
    if (do_after) begin
      if (left_q != '0) begin
        left_d    = left_q - 3'd1;
        ticks_d   = clamp_ticks(pattern_q[0] ? DASH_TICKS : DOT_TICKS);
        pattern_d = {1'b0, pattern_q[3:1]};
        phase_d   = PH_MARK;
      end else begin
        ticks_d = clamp_ticks(char_gap_q);
        phase_d = (ticks_d != '0) ? PH_CGAP : PH_IDLE;
      end
    end

    out_data_d = {taken, (phase_d != PH_IDLE), (phase_d == PH_MARK)};
  end

  // Keyer state and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      ticks_q     <= '0;
      pattern_q   <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_q     <= phase_d;
        ticks_q     <= ticks_d;
        pattern_q   <= pattern_d;
        left_q      <= left_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= out_data_d;
    end
  end

  // Gap registers; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_gap_q <= ELEMENT_GAP_RST;
      char_gap_q    <= CHAR_GAP_RST;
      word_gap_q    <= WORD_GAP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ELEMENT_GAP: element_gap_q <= cfg_data_i;
        REG_CHAR_GAP:    char_gap_q    <= cfg_data_i;
        REG_WORD_GAP:    word_gap_q    <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_data_q};

  // Checks on the keyer's own logic.
  `ASSERT_NEVER(a_busy_has_ticks, clk_i, rst_ni, (phase_q != PH_IDLE) && (ticks_q == '0), "active phase with empty tick counter")
  `ASSERT_PROP(a_xfer_gives_result, clk_i, rst_ni, in_xfer |=> m_axis_tvalid, "input transfer without result")
  `ASSERT_NEVER(a_lamp_implies_busy, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[0] && !m_axis_tdata[1], "lamp lit while not busy")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Morse keyer testbench
// Drives character and tick items into the keyer with random idling on both
// stream sides and checks every result against a cycle-free keyer predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import mck_pkg::*;

  // Item operations carried in s_axis_tuser.
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Register index that selects no register.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int unsigned TICK_LIMIT   = (1 << TICK_COUNT_BITS) - 1;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE_WAIT  = 4;
  localparam int unsigned LONG_HOLD    = 300;

  // Result fields as packed in the low bits of m_axis_tdata.
  typedef struct packed {
    logic taken;
    logic busy;
    logic lamp;
  } keyer_result_t;

  // Keyer predictor and store of expected results.
  class keyer_scoreboard;
    logic [2:0]    phase;
    tick_t         ticks_left;
    logic [3:0]    pattern;
    logic [2:0]    elems_left;
    gap_t          elem_gap;
    gap_t          char_gap;
    gap_t          word_gap;
    logic [7:0]    morse_codes[26];
    keyer_result_t expected_q[$];
    int unsigned   errors;

    function new();
      // Element count in the high nibble, dash bits in the low nibble.
      morse_codes = '{8'h22, 8'h41, 8'h45, 8'h31, 8'h10, 8'h44, 8'h33, 8'h40, 8'h20,
                      8'h4E, 8'h35, 8'h42, 8'h23, 8'h21, 8'h37, 8'h46, 8'h4B, 8'h32,
                      8'h30, 8'h11, 8'h34, 8'h48, 8'h36, 8'h49, 8'h4D, 8'h43};
      phase      = PH_IDLE;
      ticks_left = '0;
      pattern    = '0;
      elems_left = '0;
      elem_gap   = ELEMENT_GAP_RST;
      char_gap   = CHAR_GAP_RST;
      word_gap   = WORD_GAP_RST;
      errors     = 0;
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_gap(logic [1:0] idx, gap_t val);
      case (idx)
        REG_ELEMENT_GAP: elem_gap = val;
        REG_CHAR_GAP:    char_gap = val;
        REG_WORD_GAP:    word_gap = val;
        default: begin
        end
      endcase
    endfunction

    // Counts wider than the tick counter saturate.
    function tick_t saturate(gap_t v);
      if (int'(v) > TICK_LIMIT) begin
        return tick_t'(TICK_LIMIT);
      end
      return tick_t'(v);
    endfunction

    function void begin_mark();
      logic dash;
      dash       = pattern[0];
      pattern    = pattern >> 1;
      ticks_left = saturate(dash ? DASH_TICKS : DOT_TICKS);
      phase      = PH_MARK;
    endfunction

    // A gap of zero ticks leaves the keyer idle at once.
    function void begin_gap(logic [2:0] ph, gap_t len);
      ticks_left = saturate(len);
      phase      = (ticks_left != 0) ? ph : PH_IDLE;
    endfunction

    function void next_element();
      if (elems_left != 0) begin
        elems_left = elems_left - 3'd1;
        begin_mark();
      end else begin
        begin_gap(PH_CGAP, char_gap);
      end
    endfunction

    function void expire();
      if (phase == PH_MARK) begin
        begin_gap(PH_EGAP, elem_gap);
        if (phase == PH_IDLE) begin
          next_element();
        end
      end else if (phase == PH_EGAP) begin
        next_element();
      end else begin
        phase = PH_IDLE;
      end
    endfunction

    // Advance the keyer by one accepted item and queue the result it gives.
    function void note_item(logic op, logic [7:0] ch);
      logic [7:0]    folded;
      logic [7:0]    code;
      logic [3:0]    count;
      keyer_result_t res;
      res.taken = 1'b0;
      if (op == OP_TICK) begin
        if (phase != PH_IDLE) begin
          if (ticks_left > 1) begin
            ticks_left = ticks_left - 1'b1;
          end else begin
            ticks_left = '0;
            expire();
          end
        end
      end else if (phase == PH_IDLE) begin
        res.taken = 1'b1;
        folded    = ch & CASE_MASK;
        if (ch == CHAR_SPACE) begin
          begin_gap(PH_WGAP, word_gap);
        end else if (folded >= CHAR_UPPR_A && folded <= CHAR_UPPR_Z) begin
          code  = morse_codes[folded - CHAR_UPPR_A];
          count = code[7:4];
          if (count > MAX_ELEMENTS) begin
            count = 4'(MAX_ELEMENTS);
          end
          if (count != 0) begin
            pattern    = code[3:0];
            elems_left = 3'(count - 4'd1);
            begin_mark();
          end
        end
      end
      res.lamp = (phase == PH_MARK);
      res.busy = (phase != PH_IDLE);
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [7:0] data);
      keyer_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %02h with nothing expected", data));
        return;
      end
      want = expected_q.pop_front();
      if (data[0] !== want.lamp) begin
        report($sformatf("lamp_on %b, expected %b", data[0], want.lamp));
      end
      if (data[1] !== want.busy) begin
        report($sformatf("busy %b, expected %b", data[1], want.busy));
      end
      if (data[2] !== want.taken) begin
        report($sformatf("accepted %b, expected %b", data[2], want.taken));
      end
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  keyer_scoreboard sb;
  bit              tx_calm;
  bit              rx_calm;
  int unsigned     rx_count;
  int unsigned     cycle_count;

  morse_code_keyer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Wait length for one item; calm stretches have no idling at all.
  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 29) == 0) begin
      calm = !calm;
    end
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // Offer one item and return at the edge of its transfer with tvalid still high.
  task automatic send_item(logic op, logic [7:0] ch);
    int unsigned n;
    n = draw_wait(tx_calm);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, ch);
  endtask

  // Tick until the predicted keyer is idle again.
  task automatic drain_keyer();
    while (sb.busy()) begin
      send_item(OP_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  // Stop offering and wait for every expected result.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  // One register write, after which the channel is left idle.
  task automatic write_reg(logic [1:0] idx, gap_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_gap(idx, val);
    @(posedge clk_i);
  endtask

  task automatic write_gaps(gap_t e, gap_t c, gap_t w);
    write_reg(REG_ELEMENT_GAP, e);
    write_reg(REG_CHAR_GAP, c);
    write_reg(REG_WORD_GAP, w);
  endtask

  function automatic logic [7:0] random_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      return 8'(CHAR_UPPR_A + $urandom_range(0, 25));
    end else if (r < 70) begin
      return 8'(8'h61 + $urandom_range(0, 25));
    end else if (r < 80) begin
      return CHAR_SPACE;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly characters while idle and ticks while busy, so letters get keyed out.
  task automatic run_random(int unsigned count);
    logic op;
    repeat (count) begin
      if (!sb.busy()) begin
        op = ($urandom_range(0, 9) < 8) ? OP_CHAR : OP_TICK;
      end else begin
        op = ($urandom_range(0, 9) < 9) ? OP_TICK : OP_CHAR;
      end
      send_item(op, random_char());
    end
    drain_keyer();
    settle();
  endtask

  // Result side with random stalls and two long hold-offs.
  initial begin
    int unsigned n;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_count == 200 || rx_count == 700) begin
        n = LONG_HOLD;
      end else begin
        n = draw_wait(rx_calm);
      end
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
      rx_count++;
    end
  end

  // Stimulus sequence.
  initial begin
    logic [7:0] ignored_chars[8];
    ignored_chars = '{8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'hE1, 8'hA0};
    sb = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_CHAR;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_ELEMENT_GAP;
    cfg_data_i    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items at the reset gaps: a tick while idle, characters that
    // are taken and ignored, a letter with a refused character behind it,
    // and a space.
    send_item(OP_TICK, 8'hFF);
    foreach (ignored_chars[i]) begin
      send_item(OP_CHAR, ignored_chars[i]);
    end
    send_item(OP_CHAR, 8'h45);   // E: a single dot
    send_item(OP_CHAR, 8'h4B);   // refused while busy
    drain_keyer();
    send_item(OP_CHAR, CHAR_SPACE);
    drain_keyer();
    settle();

    run_random(220);

    // Zero gaps: marks run back to back and a space stays idle.
    write_gaps(8'd0, 8'd0, 8'd0);
    write_reg(REG_UNUSED, 8'hFF);
    send_item(OP_CHAR, 8'h54);   // T: a single dash
    drain_keyer();
    send_item(OP_CHAR, 8'h71);   // q: four elements
    drain_keyer();
    send_item(OP_CHAR, CHAR_SPACE);
    send_item(OP_CHAR, 8'h7A);   // z
    drain_keyer();
    settle();
    run_random(200);

    // Largest gaps: a space waits out the full word gap.
    write_gaps(8'hFF, 8'hFF, 8'hFF);
    send_item(OP_CHAR, CHAR_SPACE);
    drain_keyer();
    settle();

    write_gaps(gap_t'($urandom_range(0, 9)), gap_t'($urandom_range(0, 9)),
               gap_t'($urandom_range(0, 9)));
    run_random(200);

    write_gaps(gap_t'($urandom_range(0, 3)), gap_t'($urandom_range(0, 3)),
               gap_t'($urandom_range(0, 3)));
    write_reg(REG_UNUSED, 8'h00);
    run_random(200);

    repeat (SETTLE_WAIT) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mck_pkg.sv
rtl/morse_code_keyer_unit.sv
tb/tb.sv
